// ===== rtl/sfat_pkg.sv =====
// Shared types, constants and helper functions of the scheduled feed actuator timer.
`default_nettype none
package sfat_pkg;

  localparam int NUM_ENTRIES = 3;
  localparam int IDX_W       = 2;
  localparam int DUR_W       = 16;
  localparam int ANGLE_W     = 8;
  localparam int TIME_W      = 17;
  localparam int ENTRY_W     = 35;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 6;

  localparam logic [ANGLE_W-1:0] ANGLE_SMALL   = 8'd60;
  localparam logic [ANGLE_W-1:0] ANGLE_MEDIUM  = 8'd120;
  localparam logic [ANGLE_W-1:0] ANGLE_BIG     = 8'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX     = 8'd180;
  localparam logic [DUR_W-1:0]   DEFAULT_DELAY = 16'd10000;
  localparam logic [DUR_W-1:0]   MAX16         = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_FEED  = 2'd1,
    OP_ESTOP = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    REG_COUNT      = 3'd0,
    REG_ENTRY0     = 3'd1,
    REG_ENTRY1     = 3'd2,
    REG_ENTRY2     = 3'd3,
    REG_REST_ANGLE = 3'd4,
    REG_DELAY      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [DUR_W-1:0] duration_ms;
    logic [1:0]       size;
    logic [5:0]       second;
    logic [5:0]       minute;
    logic [4:0]       hour;
  } entry_t;

  typedef struct packed {
    logic [1:0]                   count;
    entry_t [NUM_ENTRIES-1:0]     entry;
    logic [ANGLE_W-1:0]           rest_angle;
    logic [DUR_W-1:0]             reset_delay;
  } cfg_t;

  typedef struct packed {
    logic                   feed_active;
    logic [DUR_W-1:0]       feed_elapsed;
    logic [DUR_W-1:0]       feed_length;
    logic [ANGLE_W-1:0]     held_angle;
    logic                   timed_flag;
    logic [NUM_ENTRIES-1:0] fired_flags;
    logic                   reset_waiting;
    logic [DUR_W-1:0]       reset_elapsed;
    logic                   estop_on;
  } state_t;

  function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] a);
    return (a > ANGLE_MAX) ? ANGLE_MAX : a;
  endfunction

  function automatic logic [ANGLE_W-1:0] size_angle(input logic [1:0] size,
                                                     input logic [ANGLE_W-1:0] rest);
    logic [ANGLE_W-1:0] a;
    unique case (size)
      2'd0:    a = ANGLE_SMALL;
      2'd1:    a = ANGLE_MEDIUM;
      2'd2:    a = ANGLE_BIG;
      default: a = clamp_angle(rest);
    endcase
    return a;
  endfunction

  // Seconds of the day; out-of-range fields just add up.
  function automatic logic [TIME_W-1:0] time_total(input logic [4:0] h,
                                                    input logic [5:0] m,
                                                    input logic [5:0] s);
    return TIME_W'(h) * TIME_W'(3600) + TIME_W'(m) * TIME_W'(60) + TIME_W'(s);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/scheduled_feed_actuator_timer_core.sv =====
// Top level of the scheduled feed actuator timer: input stage, state, result register.
// The input register loads at the transfer edge; the next-state logic feeds the result
//   register when the stage advances, which a stalled output can hold off.
// Throughput: one item per cycle unless the output stalls (single next-state pass).
// Reset (rst, synchronous): timer state clears (held servo angle 0, stop off),
//   registers to count 3, entries 0, rest angle 0, delay 10000.
`default_nettype none
module scheduled_feed_actuator_timer_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    op,
  input  wire logic [4:0]                    rtc_hour,
  input  wire logic [5:0]                    rtc_minute,
  input  wire logic [5:0]                    rtc_second,
  input  wire logic [1:0]                    feed_size,
  input  wire logic [15:0]                   feed_duration_ms,
  input  wire logic                          estop_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         servo_angle,
  output logic                               feeding,
  output logic                               feed_was_timed,
  output logic [2:0]                         fired_mask,
  output logic                               servo_enabled,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sfat_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [sfat_pkg::DATA_W-1:0]   pwdata,
  output logic      [sfat_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  sfat_pkg::cfg_t   cfg;
  sfat_pkg::state_t st;
  sfat_pkg::state_t st_next;

  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [4:0]  s1_hour;
  logic [5:0]  s1_minute;
  logic [5:0]  s1_second;
  logic [1:0]  s1_size;
  logic [15:0] s1_duration;
  logic        s1_estop;
  logic        adv;

  assign pready   = 1'b1;
  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  sfat_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op       <= op;
      s1_hour     <= rtc_hour;
      s1_minute   <= rtc_minute;
      s1_second   <= rtc_second;
      s1_size     <= feed_size;
      s1_duration <= feed_duration_ms;
      s1_estop    <= estop_value;
    end
  end

  sfat_step u_step (
    .cur              (st),
    .cfg              (cfg),
    .op               (s1_op),
    .rtc_hour         (s1_hour),
    .rtc_minute       (s1_minute),
    .rtc_second       (s1_second),
    .feed_size        (s1_size),
    .feed_duration_ms (s1_duration),
    .estop_value      (s1_estop),
    .nxt              (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  // result register; a new result loads when the stage advances
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      servo_angle    <= st_next.held_angle;
      feeding        <= st_next.feed_active;
      feed_was_timed <= st_next.feed_active && st_next.timed_flag;
      fired_mask     <= 3'(st_next.fired_flags);
      servo_enabled  <= !st_next.estop_on;
    end
  end

  // stop blocks a manual feed
  a_estop_blocks_feed: assert property (@(posedge clk) disable iff (rst)
    adv && s1_op == sfat_pkg::OP_FEED && st.estop_on && !st.feed_active
    |=> !st.feed_active)
    else $error("feed started while emergency stop on");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> servo_angle <= sfat_pkg::ANGLE_MAX)
    else $error("servo angle above limit");

  a_timed_needs_feed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !feeding |-> !feed_was_timed)
    else $error("timed flag without running feed");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(st))
    else $error("state changed without a transfer");

endmodule
`default_nettype wire

// ===== rtl/sfat_regs.sv =====
// APB configuration registers of the scheduled feed actuator timer.
`default_nettype none
module sfat_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sfat_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [sfat_pkg::DATA_W-1:0]   pwdata,
  output logic      [sfat_pkg::DATA_W-1:0]   prdata,
  output sfat_pkg::cfg_t                     cfg
);

  sfat_pkg::reg_idx_t idx;
  logic               wr;

  assign idx = sfat_pkg::reg_idx_t'(paddr[sfat_pkg::ADDR_W-1:3]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count       <= 2'd3;
      cfg.entry       <= '0;
      cfg.rest_angle  <= '0;
      cfg.reset_delay <= sfat_pkg::DEFAULT_DELAY;
    end else if (wr) begin
      unique case (idx)
        sfat_pkg::REG_COUNT:      cfg.count       <= pwdata[1:0];
        sfat_pkg::REG_ENTRY0:     cfg.entry[0]    <= sfat_pkg::entry_t'(pwdata[sfat_pkg::ENTRY_W-1:0]);
        sfat_pkg::REG_ENTRY1:     cfg.entry[1]    <= sfat_pkg::entry_t'(pwdata[sfat_pkg::ENTRY_W-1:0]);
        sfat_pkg::REG_ENTRY2:     cfg.entry[2]    <= sfat_pkg::entry_t'(pwdata[sfat_pkg::ENTRY_W-1:0]);
        sfat_pkg::REG_REST_ANGLE: cfg.rest_angle  <= pwdata[sfat_pkg::ANGLE_W-1:0];
        sfat_pkg::REG_DELAY:      cfg.reset_delay <= pwdata[sfat_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sfat_pkg::REG_COUNT:      prdata = sfat_pkg::DATA_W'(cfg.count);
      sfat_pkg::REG_ENTRY0:     prdata = sfat_pkg::DATA_W'(cfg.entry[0]);
      sfat_pkg::REG_ENTRY1:     prdata = sfat_pkg::DATA_W'(cfg.entry[1]);
      sfat_pkg::REG_ENTRY2:     prdata = sfat_pkg::DATA_W'(cfg.entry[2]);
      sfat_pkg::REG_REST_ANGLE: prdata = sfat_pkg::DATA_W'(cfg.rest_angle);
      sfat_pkg::REG_DELAY:      prdata = sfat_pkg::DATA_W'(cfg.reset_delay);
      default:                  prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/sfat_step.sv =====
// Next-state logic of the feed timer for one item.
`default_nettype none
module sfat_step (
  input  sfat_pkg::state_t                 cur,
  input  sfat_pkg::cfg_t                   cfg,
  input  wire logic [1:0]                  op,
  input  wire logic [4:0]                  rtc_hour,
  input  wire logic [5:0]                  rtc_minute,
  input  wire logic [5:0]                  rtc_second,
  input  wire logic [1:0]                  feed_size,
  input  wire logic [sfat_pkg::DUR_W-1:0]  feed_duration_ms,
  input  wire logic                        estop_value,
  output sfat_pkg::state_t                 nxt
);

  logic [sfat_pkg::IDX_W-1:0]       n_use;
  logic [sfat_pkg::IDX_W-1:0]       last;
  logic [sfat_pkg::NUM_ENTRIES-1:0] in_use;
  logic [sfat_pkg::TIME_W-1:0]      now;
  logic [sfat_pkg::NUM_ENTRIES-1:0] hit;

  // Entries in use: count 0 acts as 1, clipped to the entry count.
  always_comb begin
    if (cfg.count == 2'd0) begin
      n_use = 2'd1;
    end else if (cfg.count > sfat_pkg::IDX_W'(sfat_pkg::NUM_ENTRIES)) begin
      n_use = sfat_pkg::IDX_W'(sfat_pkg::NUM_ENTRIES);
    end else begin
      n_use = cfg.count;
    end
    last = n_use - 2'd1;
    for (int i = 0; i < sfat_pkg::NUM_ENTRIES; i++) begin
      in_use[i] = sfat_pkg::IDX_W'(i) < n_use;
    end
  end

  assign now = sfat_pkg::time_total(rtc_hour, rtc_minute, rtc_second);

  always_comb begin
    for (int i = 0; i < sfat_pkg::NUM_ENTRIES; i++) begin
      hit[i] = in_use[i] && !cur.fired_flags[i] &&
               (sfat_pkg::time_total(cfg.entry[i].hour, cfg.entry[i].minute,
                                     cfg.entry[i].second) == now);
    end
  end

  always_comb begin
    logic started;
    nxt     = cur;
    started = 1'b0;
    unique case (op)
      sfat_pkg::OP_TICK: begin
        // end check
        if (nxt.feed_active) begin
          if (nxt.feed_elapsed != sfat_pkg::MAX16) begin
            nxt.feed_elapsed = nxt.feed_elapsed + 16'd1;
          end
          if (nxt.feed_elapsed >= nxt.feed_length) begin
            nxt.feed_active = 1'b0;
            nxt.held_angle  = sfat_pkg::clamp_angle(cfg.rest_angle);
          end
        end
        // alarm compare: every hit is marked, the first one may start a feed
        for (int i = 0; i < sfat_pkg::NUM_ENTRIES; i++) begin
          if (hit[i]) begin
            if (!nxt.feed_active && !nxt.estop_on && !started) begin
              started          = 1'b1;
              nxt.feed_active  = 1'b1;
              nxt.feed_elapsed = '0;
              nxt.feed_length  = cfg.entry[i].duration_ms;
              nxt.held_angle   = sfat_pkg::size_angle(cfg.entry[i].size, cfg.rest_angle);
              nxt.timed_flag   = 1'b1;
            end
            nxt.fired_flags[i] = 1'b1;
          end
        end
        // reset delay
        if (nxt.reset_waiting && nxt.reset_elapsed != sfat_pkg::MAX16) begin
          nxt.reset_elapsed = nxt.reset_elapsed + 16'd1;
        end
        if (nxt.fired_flags[last]) begin
          if (!nxt.reset_waiting) begin
            nxt.reset_waiting = 1'b1;
            nxt.reset_elapsed = '0;
          end
          if (nxt.reset_elapsed >= cfg.reset_delay) begin
            nxt.reset_waiting = 1'b0;
            nxt.fired_flags   = nxt.fired_flags & ~in_use;
          end
        end
      end
      sfat_pkg::OP_FEED: begin
        if (!nxt.feed_active && !nxt.estop_on) begin
          nxt.feed_active  = 1'b1;
          nxt.feed_elapsed = '0;
          nxt.feed_length  = feed_duration_ms;
          nxt.held_angle   = sfat_pkg::size_angle(feed_size, cfg.rest_angle);
          nxt.timed_flag   = 1'b0;
        end
      end
      sfat_pkg::OP_ESTOP: begin
        nxt.estop_on = estop_value;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== bench/scheduled_feed_actuator_timer_core_tb.sv =====
// Self-checking testbench for the scheduled feed actuator timer core.
`default_nettype none
module scheduled_feed_actuator_timer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfat_pkg::*;

  localparam logic [1:0] OP_NONE     = 2'd3;  // unused op code, reports state only
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         PHASES      = 8;
  localparam int         PHASE_ITEMS = 240;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  rtc_hour;
    logic [5:0]  rtc_minute;
    logic [5:0]  rtc_second;
    logic [1:0]  feed_size;
    logic [15:0] feed_duration_ms;
    logic        estop_value;
  } feeder_item_t;

  typedef struct packed {
    logic [7:0] servo_angle;
    logic       feeding;
    logic       feed_was_timed;
    logic [2:0] fired_mask;
    logic       servo_enabled;
  } feeder_status_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [4:0]  rtc_hour;
  logic [5:0]  rtc_minute;
  logic [5:0]  rtc_second;
  logic [1:0]  feed_size;
  logic [15:0] feed_duration_ms;
  logic        estop_value;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  servo_angle;
  logic        feeding;
  logic        feed_was_timed;
  logic [2:0]  fired_mask;
  logic        servo_enabled;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic        pready;

  scheduled_feed_actuator_timer_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .rtc_hour(rtc_hour), .rtc_minute(rtc_minute), .rtc_second(rtc_second),
    .feed_size(feed_size), .feed_duration_ms(feed_duration_ms), .estop_value(estop_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .servo_angle(servo_angle), .feeding(feeding), .feed_was_timed(feed_was_timed),
    .fired_mask(fired_mask), .servo_enabled(servo_enabled),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Feeder state mirror
  logic        feed_on;
  logic [15:0] feed_cnt;
  logic [15:0] feed_len;
  logic [7:0]  held_angle;
  logic        timed_on;
  logic [2:0]  fired;
  logic        clear_wait;
  logic [15:0] clear_cnt;
  logic        stop_on;

  // Register mirror
  logic [1:0]  cfg_count;
  entry_t      cfg_entry [NUM_ENTRIES];
  logic [7:0]  cfg_rest;
  logic [15:0] cfg_delay;

  feeder_status_t expected_status[$];
  int             errors = 0;
  int             cycles = 0;
  logic           gaps_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [7:0] limit_angle(logic [7:0] a);
    return (a > ANGLE_MAX) ? ANGLE_MAX : a;
  endfunction

  function automatic logic [7:0] angle_for_size(logic [1:0] sz);
    case (sz)
      2'd0:    return ANGLE_SMALL;
      2'd1:    return ANGLE_MEDIUM;
      2'd2:    return ANGLE_BIG;
      default: return limit_angle(cfg_rest);
    endcase
  endfunction

  function automatic int day_seconds(logic [4:0] h, logic [5:0] m, logic [5:0] s);
    return int'(h) * 3600 + int'(m) * 60 + int'(s);
  endfunction

  function automatic void clear_feeder();
    cfg_count  = 2'd3;
    for (int i = 0; i < NUM_ENTRIES; i++) cfg_entry[i] = '0;
    cfg_rest   = 8'd0;
    cfg_delay  = DEFAULT_DELAY;
    feed_on    = 1'b0;
    feed_cnt   = '0;
    feed_len   = '0;
    held_angle = 8'd0;
    timed_on   = 1'b0;
    fired      = '0;
    clear_wait = 1'b0;
    clear_cnt  = '0;
    stop_on    = 1'b0;
  endfunction

  function automatic void start_feed(logic [1:0] sz, logic [15:0] len, logic by_alarm);
    if (feed_on || stop_on) return;
    feed_on    = 1'b1;
    feed_cnt   = '0;
    feed_len   = len;
    held_angle = angle_for_size(sz);
    timed_on   = by_alarm;
  endfunction

  function automatic void clock_tick(logic [4:0] h, logic [5:0] m, logic [5:0] s);
    int n;
    int now;
    n   = (cfg_count == 2'd0) ? 1 : ((int'(cfg_count) > NUM_ENTRIES) ? NUM_ENTRIES
                                                                      : int'(cfg_count));
    now = day_seconds(h, m, s);
    if (feed_on) begin
      if (feed_cnt != MAX16) feed_cnt = feed_cnt + 16'd1;
      if (feed_cnt >= feed_len) begin
        feed_on    = 1'b0;
        held_angle = limit_angle(cfg_rest);
      end
    end
    for (int i = 0; i < n; i++) begin
      if (!fired[i] && day_seconds(cfg_entry[i].hour, cfg_entry[i].minute,
                                   cfg_entry[i].second) == now) begin
        start_feed(cfg_entry[i].size, cfg_entry[i].duration_ms, 1'b1);
        fired[i] = 1'b1;
      end
    end
    if (clear_wait && clear_cnt != MAX16) clear_cnt = clear_cnt + 16'd1;
    if (fired[n-1]) begin
      if (!clear_wait) begin
        clear_wait = 1'b1;
        clear_cnt  = '0;
      end
      if (clear_cnt >= cfg_delay) begin
        clear_wait = 1'b0;
        fired      = fired & ~3'((1 << n) - 1);
      end
    end
  endfunction

  function automatic feeder_status_t feeder_step(feeder_item_t it);
    feeder_status_t st;
    case (it.op)
      OP_TICK:  clock_tick(it.rtc_hour, it.rtc_minute, it.rtc_second);
      OP_FEED:  start_feed(it.feed_size, it.feed_duration_ms, 1'b0);
      OP_ESTOP: stop_on = it.estop_value;
      default:  ;
    endcase
    st.servo_angle    = held_angle;
    st.feeding        = feed_on;
    st.feed_was_timed = feed_on && timed_on;
    st.fired_mask     = fired;
    st.servo_enabled  = !stop_on;
    return st;
  endfunction

  function automatic logic [63:0] pack_entry(logic [4:0] h, logic [5:0] m, logic [5:0] s,
                                             logic [1:0] sz, logic [15:0] dur);
    return 64'({dur, sz, s, m, h});
  endfunction

  // Unused fields get random values; the block must ignore them.
  function automatic feeder_item_t noise_item();
    feeder_item_t it;
    it.op               = 2'($urandom_range(0, 3));
    it.rtc_hour         = 5'($urandom_range(0, 31));
    it.rtc_minute       = 6'($urandom_range(0, 63));
    it.rtc_second       = 6'($urandom_range(0, 63));
    it.feed_size        = 2'($urandom_range(0, 3));
    it.feed_duration_ms = 16'($urandom_range(0, 65535));
    it.estop_value      = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_item(feeder_item_t it);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    op               <= it.op;
    rtc_hour         <= it.rtc_hour;
    rtc_minute       <= it.rtc_minute;
    rtc_second       <= it.rtc_second;
    feed_size        <= it.feed_size;
    feed_duration_ms <= it.feed_duration_ms;
    estop_value      <= it.estop_value;
    do @(posedge clk); while (!in_ready);
    expected_status.push_back(feeder_step(it));
  endtask

  task automatic send_tick(logic [4:0] h, logic [5:0] m, logic [5:0] s);
    feeder_item_t it;
    it            = noise_item();
    it.op         = OP_TICK;
    it.rtc_hour   = h;
    it.rtc_minute = m;
    it.rtc_second = s;
    send_item(it);
  endtask

  task automatic send_feed(logic [1:0] sz, logic [15:0] dur);
    feeder_item_t it;
    it                  = noise_item();
    it.op               = OP_FEED;
    it.feed_size        = sz;
    it.feed_duration_ms = dur;
    send_item(it);
  endtask

  task automatic send_stop(logic v);
    feeder_item_t it;
    it             = noise_item();
    it.op          = OP_ESTOP;
    it.estop_value = v;
    send_item(it);
  endtask

  task automatic send_other();
    feeder_item_t it;
    it    = noise_item();
    it.op = OP_NONE;
    send_item(it);
  endtask

  // Drop valid, drain all pending results, then let the pipeline go quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 8);
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_COUNT:      cfg_count    = val[1:0];
      REG_ENTRY0:     cfg_entry[0] = entry_t'(val[ENTRY_W-1:0]);
      REG_ENTRY1:     cfg_entry[1] = entry_t'(val[ENTRY_W-1:0]);
      REG_ENTRY2:     cfg_entry[2] = entry_t'(val[ENTRY_W-1:0]);
      REG_REST_ANGLE: cfg_rest     = val[7:0];
      REG_DELAY:      cfg_delay    = val[15:0];
      default:        ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= !gaps_on || ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk) begin
    feeder_status_t exp_st;
    if (!rst && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        $error("result transfer with no expected status pending");
        errors++;
      end else begin
        exp_st = expected_status.pop_front();
        if (servo_angle !== exp_st.servo_angle) begin
          $error("servo_angle: expected %0d, got %0d", exp_st.servo_angle, servo_angle);
          errors++;
        end
        if (feeding !== exp_st.feeding) begin
          $error("feeding: expected %0d, got %0d", exp_st.feeding, feeding);
          errors++;
        end
        if (feed_was_timed !== exp_st.feed_was_timed) begin
          $error("feed_was_timed: expected %0d, got %0d", exp_st.feed_was_timed,
                 feed_was_timed);
          errors++;
        end
        if (fired_mask !== exp_st.fired_mask) begin
          $error("fired_mask: expected %0d, got %0d", exp_st.fired_mask, fired_mask);
          errors++;
        end
        if (servo_enabled !== exp_st.servo_enabled) begin
          $error("servo_enabled: expected %0d, got %0d", exp_st.servo_enabled,
                 servo_enabled);
          errors++;
        end
      end
    end
  end

  // Reset entries are all 00:00:00, so a midnight tick fires all three at once.
  task automatic test_reset_values();
    send_other();
    send_tick(5'd0, 6'd0, 6'd0);
    send_tick(5'd1, 6'd2, 6'd3);
  endtask

  // Zero delay, single entry in use, stop blocking an alarm, clamped rest angle.
  task automatic test_stop_and_extremes();
    settle();
    write_reg(REG_DELAY, 64'd0);
    send_tick(5'd1, 6'd2, 6'd4);
    settle();
    write_reg(REG_REST_ANGLE, 64'd255);
    write_reg(REG_COUNT, 64'd0);
    write_reg(REG_ENTRY0, pack_entry(5'd31, 6'd63, 6'd63, 2'd3, 16'hFFFF));
    write_reg(REG_ENTRY1, pack_entry(5'd31, 6'd63, 6'd63, 2'd0, 16'd0));
    send_stop(1'b1);
    send_tick(5'd31, 6'd63, 6'd63);
    send_stop(1'b0);
    send_feed(2'd3, 16'd1);
    send_feed(2'd0, 16'hFFFF);
    send_tick(5'd0, 6'd0, 6'd0);
  endtask

  // Two entries in one second; a third matching while a feed runs, given with
  // minute 60 in place of the hour.
  task automatic test_same_second();
    settle();
    write_reg(REG_REST_ANGLE, 64'd90);
    write_reg(REG_COUNT, 64'd3);
    write_reg(REG_ENTRY0, pack_entry(5'd1, 6'd0, 6'd0, 2'd1, 16'd3));
    write_reg(REG_ENTRY1, pack_entry(5'd1, 6'd0, 6'd0, 2'd2, 16'd5));
    write_reg(REG_ENTRY2, pack_entry(5'd0, 6'd60, 6'd1, 2'd0, 16'd0));
    write_reg(REG_DELAY, 64'd65535);
    send_tick(5'd1, 6'd0, 6'd0);
    send_stop(1'b1);
    send_feed(2'd2, 16'd7);
    send_tick(5'd1, 6'd0, 6'd1);
    send_tick(5'd2, 6'd0, 6'd0);
    send_tick(5'd2, 6'd0, 6'd0);
    send_stop(1'b0);
  endtask

  // Shrinking the count keeps the mark of the entry taken out of use.
  task automatic test_count_change();
    settle();
    write_reg(REG_COUNT, 64'd2);
    write_reg(REG_DELAY, 64'd1);
    send_tick(5'd0, 6'd0, 6'd9);
    settle();
    write_reg(REG_COUNT, 64'd3);
    send_tick(5'd0, 6'd0, 6'd10);
    send_tick(5'd0, 6'd0, 6'd11);
  endtask

  // Random phases: alarms clustered near a clock that sweeps across them.
  task automatic test_random_phases();
    int base;
    int now_s;
    int r;
    int t;
    logic [15:0] dur;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      gaps_on = (ph != 2);
      base = $urandom_range(0, 86379);
      write_reg(REG_COUNT, 64'($urandom_range(0, 3)));
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        t   = base + $urandom_range(0, 12);
        dur = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 120))
                                          : 16'($urandom_range(0, 20));
        write_reg(reg_idx_t'(int'(REG_ENTRY0) + i),
                  pack_entry(5'(t / 3600), 6'((t % 3600) / 60), 6'(t % 60),
                             2'($urandom_range(0, 3)), dur));
      end
      write_reg(REG_REST_ANGLE, 64'($urandom_range(0, 255)));
      write_reg(REG_DELAY, (ph == 1) ? 64'd0 : (ph == 5) ? 64'd65535
                                               : 64'($urandom_range(0, 40)));
      now_s = (base > 2) ? base - 2 : 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 68) begin
          if ($urandom_range(0, 99) < 4) begin
            send_tick(5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)));
          end else begin
            if ($urandom_range(0, 1) == 1) now_s++;
            if ($urandom_range(0, 99) < 3) now_s = base;
            send_tick(5'(now_s / 3600), 6'((now_s % 3600) / 60), 6'(now_s % 60));
          end
        end else if (r < 82) begin
          // a blocked request may carry any length; a live one stays short
          if (feed_on || stop_on) dur = 16'($urandom_range(0, 65535));
          else if ($urandom_range(0, 9) == 0) dur = 16'($urandom_range(0, 200));
          else dur = 16'($urandom_range(0, 20));
          send_feed(2'($urandom_range(0, 3)), dur);
        end else if (r < 94) begin
          send_stop($urandom_range(0, 99) < 35);
        end else if (r < 97) begin
          send_other();
        end else begin
          send_item(noise_item());
        end
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    op               = OP_TICK;
    rtc_hour         = '0;
    rtc_minute       = '0;
    rtc_second       = '0;
    feed_size        = '0;
    feed_duration_ms = '0;
    estop_value      = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    gaps_on          = 1'b1;
    clear_feeder();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_stop_and_extremes();
    test_same_second();
    test_count_change();
    test_random_phases();

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
